[design/tnm_pkg.sv]
// tag name matcher: shared types, codes and constant name tables
// used by the interfaces, front, queue and back of tag_name_matcher
`timescale 1ns / 1ps
`default_nettype none

package tnm_pkg;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 6;
   localparam int INDEX_W = 4;
   localparam int KIND_W  = 2;

   localparam logic [OP_W-1:0] OP_TAG   = 2'd0;
   localparam logic [OP_W-1:0] OP_SUBJ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_TABLE       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INCLUDEONLY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ONLYINCLUDE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOINCLUDE   = 2'd3;

   localparam int BUILTIN_COUNT = 3;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;

   typedef logic [0:10][CHAR_W-1:0] name_type;

   localparam name_type NAME_INCLUDEONLY = "includeonly";
   localparam name_type NAME_ONLYINCLUDE = "onlyinclude";
   localparam name_type NAME_NOINCLUDE   = {"noinclude", 16'h0000};

   typedef enum logic [1:0] {
      CMD_TAG,
      CMD_SUBJ,
      CMD_CLEAR
   } cmd_kind_type;

   // subject character as stored: lowercased, with the delimiter tests done up front
   typedef struct packed {
      logic [CHAR_W-1:0] low;
      logic              delim;
      logic              slash;
      logic              gt;
   } subj_entry_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] raw;
      subj_entry_type    subj;
      logic              last;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DLM_A,
      ST_DLM_B,
      ST_CMP,
      ST_EMIT,
      ST_MISS
   } state_type;

   function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + CASE_GAP;
      end
      return c;
   endfunction

   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR ||
             c == CH_SPACE || c == CH_GT;
   endfunction

   function automatic logic [3:0] builtin_len(input logic [1:0] idx);
      logic [3:0] n;
      unique case (idx)
         2'd0:    n = 4'd11;
         2'd1:    n = 4'd11;
         2'd2:    n = 4'd9;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] builtin_char(input logic [1:0] idx,
                                                      input logic [3:0] k);
      logic [CHAR_W-1:0] c;
      c = '0;
      if (k <= 4'd10) begin
         unique case (idx)
            2'd0:    c = NAME_INCLUDEONLY[k];
            2'd1:    c = NAME_ONLYINCLUDE[k];
            2'd2:    c = NAME_NOINCLUDE[k];
            default: c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[design/tnm_if.sv]
// tag name matcher: request and response channel interfaces
// valid/ready handshake; payload widths come from tnm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tnm_req_if;
   import tnm_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [CHAR_W-1:0] char_value;
   logic              last_char;

   modport source (output valid, opcode, char_value, last_char, input ready);
   modport sink   (input valid, opcode, char_value, last_char, output ready);
endinterface

interface tnm_rsp_if;
   import tnm_pkg::*;
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  name_char;
   logic               found;
   logic [LEN_W-1:0]   match_length;
   logic [INDEX_W-1:0] table_index;
   logic [KIND_W-1:0]  internal_kind;
   logic               last_result;

   modport source (output valid, name_char, found, match_length, table_index,
                   internal_kind, last_result, input ready);
   modport sink   (input valid, name_char, found, match_length, table_index,
                   internal_kind, last_result, output ready);
endinterface

`default_nettype wire

[design/tnm_front.sv]
// tag name matcher front: takes request beats and classifies them into commands
// depends on tnm_pkg and tnm_req_if; feeds tnm_fifo
`timescale 1ns / 1ps
`default_nettype none

module tnm_front (
   tnm_req_if.sink          req_if,
   input  logic             queue_full,
   output logic             queue_push,
   output tnm_pkg::cmd_type queue_cmd
);
   import tnm_pkg::*;

   logic known_op;

   assign req_if.ready = !queue_full;

   always_comb begin
      known_op       = 1'b1;
      queue_cmd.kind = CMD_CLEAR;
      unique case (req_if.opcode)
         OP_TAG:   queue_cmd.kind = CMD_TAG;
         OP_SUBJ:  queue_cmd.kind = CMD_SUBJ;
         OP_CLEAR: queue_cmd.kind = CMD_CLEAR;
         default:  known_op = 1'b0;
      endcase
      queue_cmd.raw        = req_if.char_value;
      queue_cmd.subj.low   = lower_ascii(req_if.char_value);
      queue_cmd.subj.delim = is_delim(req_if.char_value);
      queue_cmd.subj.slash = req_if.char_value == CH_SLASH;
      queue_cmd.subj.gt    = req_if.char_value == CH_GT;
      queue_cmd.last       = req_if.last_char;
   end

   // the unused opcode is taken and dropped here
   assign queue_push = req_if.valid && !queue_full && known_op;

endmodule

`default_nettype wire

[design/tnm_fifo.sv]
// tag name matcher command queue between front and back
// depends on tnm_pkg for the command type and depth
`timescale 1ns / 1ps
`default_nettype none

module tnm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tnm_pkg::cmd_type push_cmd,
   input  logic             pop,
   output tnm_pkg::cmd_type pop_cmd,
   output logic             full,
   output logic             empty
);
   import tnm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[design/tnm_back.sv]
// tag name matcher back: tag table and subject storage, match walk, result register
// depends on tnm_pkg and tnm_rsp_if; pops commands from tnm_fifo
`timescale 1ns / 1ps
`default_nettype none

module tnm_back #(
   parameter int MAX_TAGS    = 16,
   parameter int MAX_TAG_LEN = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  tnm_pkg::cmd_type queue_cmd,
   output logic             queue_pop,
   tnm_rsp_if.source        rsp_if
);
   import tnm_pkg::*;

   localparam int CNT_W      = $clog2(MAX_TAGS + 1);
   localparam int IDX_W      = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int POS_W      = $clog2(MAX_TAG_LEN + 2);
   localparam int SUBJ_CAP   = MAX_TAG_LEN + 3;
   localparam int SLEN_W     = $clog2(SUBJ_CAP + 1);
   localparam int SADDR_W    = $clog2(SUBJ_CAP);
   localparam int CMP_W      = SLEN_W + 1;
   localparam int TEXT_DEPTH = MAX_TAGS * MAX_TAG_LEN;
   localparam int TADDR_W    = $clog2(TEXT_DEPTH);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     tag_count_ff, tag_count_in;
   logic [POS_W-1:0]     load_pos_ff, load_pos_in;
   logic [TADDR_W-1:0]   load_base_ff, load_base_in;
   logic [SLEN_W-1:0]    subj_len_ff, subj_len_in;
   logic                 first_slash_ff, first_slash_in;
   logic [CNT_W-1:0]     cand_ff, cand_in;
   logic [TADDR_W-1:0]   walk_base_ff, walk_base_in;
   logic                 builtin_ff, builtin_in;
   logic [1:0]           bi_ff, bi_in;
   logic [POS_W-1:0]     k_ff, k_in;
   logic                 dlm_delim_ff, dlm_delim_in;
   logic                 dlm_slash_ff, dlm_slash_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [POS_W-1:0]     tag_len_ff [MAX_TAGS];
   logic                 len_we;

   logic [CHAR_W-1:0]    tag_mem [TEXT_DEPTH];
   logic                 tag_we;
   logic [TADDR_W-1:0]   tag_waddr, tag_raddr;
   logic [CHAR_W-1:0]    tag_rd_ff;

   subj_entry_type       subj_mem [SUBJ_CAP];
   logic                 subj_we;
   logic [SADDR_W-1:0]   subj_waddr, subj_raddr;
   subj_entry_type       subj_rd_ff;

   logic                 table_room;
   logic [POS_W-1:0]     tag_pos_step;
   logic [POS_W-1:0]     cur_len;
   logic                 off;
   logic [SLEN_W-1:0]    len_eff;
   logic                 eligible;
   logic                 room2;
   logic                 dlm_ok;
   logic [CMP_W-1:0]     dlm_addr0, dlm_addr1;
   logic [CHAR_W-1:0]    name_cur;
   logic                 char_eq;
   logic                 name_last;
   logic                 out_free;
   logic                 table_done;
   logic                 builtin_done;
   logic                 advance;
   logic [POS_W-1:0]     k_next;

   // candidate under test: loaded entry cand_ff, or built-in name bi_ff
   always_comb begin
      table_room   = tag_count_ff < CNT_W'(MAX_TAGS);
      tag_pos_step = (load_pos_ff < POS_W'(MAX_TAG_LEN)) ? load_pos_ff + 1'b1
                                                          : POS_W'(MAX_TAG_LEN + 1);
      cur_len      = builtin_ff ? POS_W'(builtin_len(bi_ff))
                                : tag_len_ff[cand_ff[IDX_W-1:0]];
      off          = builtin_ff && first_slash_ff;
      len_eff      = subj_len_ff - SLEN_W'(off);
      eligible     = cur_len != '0 && cur_len <= POS_W'(MAX_TAG_LEN) &&
                     CMP_W'(cur_len) < CMP_W'(len_eff);
      room2        = CMP_W'(cur_len) + CMP_W'(2) <= CMP_W'(len_eff);
      dlm_ok       = dlm_delim_ff || (dlm_slash_ff && room2 && subj_rd_ff.gt);
      dlm_addr0    = CMP_W'(off) + CMP_W'(cur_len);
      dlm_addr1    = (dlm_addr0 + 1'b1 >= CMP_W'(SUBJ_CAP)) ? CMP_W'(SUBJ_CAP - 1)
                                                            : dlm_addr0 + 1'b1;
      name_cur     = builtin_ff ? builtin_char(bi_ff, k_ff[3:0]) : tag_rd_ff;
      char_eq      = subj_rd_ff.low == name_cur;
      name_last    = k_ff == cur_len - 1'b1;
      out_free     = !rsp_valid_ff || rsp_if.ready;
      table_done   = !builtin_ff && cand_ff >= tag_count_ff;
      builtin_done = builtin_ff && bi_ff == 2'(BUILTIN_COUNT);
      k_next       = k_ff + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty && queue_cmd.kind == CMD_SUBJ && queue_cmd.last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (builtin_done) begin
               state_in = ST_MISS;
            end else if (!table_done && eligible) begin
               state_in = ST_DLM_A;
            end
         end
         ST_DLM_A: state_in = ST_DLM_B;
         ST_DLM_B: state_in = dlm_ok ? ST_CMP : ST_SETUP;
         ST_CMP: begin
            if (!char_eq) begin
               state_in = ST_SETUP;
            end else if (name_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && name_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      queue_pop      = 1'b0;
      tag_we         = 1'b0;
      len_we         = 1'b0;
      subj_we        = 1'b0;
      tag_waddr      = TADDR_W'(load_base_ff + TADDR_W'(load_pos_ff));
      subj_waddr     = SADDR_W'(subj_len_ff);
      tag_raddr      = TADDR_W'(walk_base_ff + TADDR_W'(k_ff));
      subj_raddr     = SADDR_W'(CMP_W'(off) + CMP_W'(k_ff));
      advance        = 1'b0;

      tag_count_in   = tag_count_ff;
      load_pos_in    = load_pos_ff;
      load_base_in   = load_base_ff;
      subj_len_in    = subj_len_ff;
      first_slash_in = first_slash_ff;
      cand_in        = cand_ff;
      walk_base_in   = walk_base_ff;
      builtin_in     = builtin_ff;
      bi_in          = bi_ff;
      k_in           = k_ff;
      dlm_delim_in   = dlm_delim_ff;
      dlm_slash_in   = dlm_slash_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in    = rsp_char_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               unique case (queue_cmd.kind)
                  CMD_TAG: begin
                     tag_we = table_room && load_pos_ff < POS_W'(MAX_TAG_LEN);
                     if (table_room) begin
                        load_pos_in = tag_pos_step;
                     end
                     if (queue_cmd.last) begin
                        load_pos_in = '0;
                        if (table_room) begin
                           len_we       = 1'b1;
                           tag_count_in = tag_count_ff + 1'b1;
                           load_base_in = TADDR_W'(load_base_ff + MAX_TAG_LEN);
                        end
                     end
                  end
                  CMD_SUBJ: begin
                     if (subj_len_ff < SLEN_W'(SUBJ_CAP)) begin
                        subj_we     = 1'b1;
                        subj_len_in = subj_len_ff + 1'b1;
                     end
                     if (subj_len_ff == '0) begin
                        first_slash_in = queue_cmd.subj.slash;
                     end
                     if (queue_cmd.last) begin
                        cand_in      = '0;
                        walk_base_in = '0;
                        builtin_in   = 1'b0;
                        bi_in        = '0;
                     end
                  end
                  CMD_CLEAR: begin
                     tag_count_in = '0;
                     load_pos_in  = '0;
                     load_base_in = '0;
                     subj_len_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            if (table_done) begin
               // loaded table exhausted: built-in names next, past a leading slash
               builtin_in = 1'b1;
               bi_in      = '0;
            end else if (!builtin_done) begin
               if (eligible) begin
                  subj_raddr = SADDR_W'(dlm_addr0);
               end else begin
                  advance = 1'b1;
               end
            end
         end
         ST_DLM_A: begin
            subj_raddr   = SADDR_W'(dlm_addr1);
            dlm_delim_in = subj_rd_ff.delim;
            dlm_slash_in = subj_rd_ff.slash;
         end
         ST_DLM_B: begin
            if (dlm_ok) begin
               k_in       = '0;
               tag_raddr  = walk_base_ff;
               subj_raddr = SADDR_W'(off);
            end else begin
               advance = 1'b1;
            end
         end
         ST_CMP: begin
            if (!char_eq) begin
               advance = 1'b1;
            end else if (name_last) begin
               // rewind to the first character for the emit pass
               k_in      = '0;
               tag_raddr = walk_base_ff;
            end else begin
               k_in       = k_next;
               tag_raddr  = TADDR_W'(walk_base_ff + TADDR_W'(k_next));
               subj_raddr = SADDR_W'(CMP_W'(off) + CMP_W'(k_next));
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = name_cur;
               rsp_found_in = 1'b1;
               rsp_len_in   = LEN_W'(cur_len);
               rsp_index_in = builtin_ff ? '0 : INDEX_W'(cand_ff);
               rsp_kind_in  = builtin_ff ? KIND_W'(bi_ff + 2'd1) : KIND_TABLE;
               rsp_last_in  = name_last;
               if (name_last) begin
                  subj_len_in = '0;
               end else begin
                  k_in      = k_next;
                  tag_raddr = TADDR_W'(walk_base_ff + TADDR_W'(k_next));
               end
            end
         end
         ST_MISS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_found_in = 1'b0;
               rsp_len_in   = '0;
               rsp_index_in = '0;
               rsp_kind_in  = KIND_TABLE;
               rsp_last_in  = 1'b1;
               subj_len_in  = '0;
            end
         end
         default: ;
      endcase

      if (advance) begin
         if (builtin_ff) begin
            bi_in = bi_ff + 2'd1;
         end else begin
            cand_in      = cand_ff + 1'b1;
            walk_base_in = TADDR_W'(walk_base_ff + MAX_TAG_LEN);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tag_count_ff   <= '0;
         load_pos_ff    <= '0;
         load_base_ff   <= '0;
         subj_len_ff    <= '0;
         first_slash_ff <= 1'b0;
         cand_ff        <= '0;
         walk_base_ff   <= '0;
         builtin_ff     <= 1'b0;
         bi_ff          <= '0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tag_count_ff   <= tag_count_in;
         load_pos_ff    <= load_pos_in;
         load_base_ff   <= load_base_in;
         subj_len_ff    <= subj_len_in;
         first_slash_ff <= first_slash_in;
         cand_ff        <= cand_in;
         walk_base_ff   <= walk_base_in;
         builtin_ff     <= builtin_in;
         bi_ff          <= bi_in;
         k_ff           <= k_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dlm_delim_ff <= dlm_delim_in;
      dlm_slash_ff <= dlm_slash_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_found_ff <= rsp_found_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_index_ff <= rsp_index_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
      if (len_we) begin
         tag_len_ff[tag_count_ff[IDX_W-1:0]] <= tag_pos_step;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= queue_cmd.raw;
      end
      tag_rd_ff <= tag_mem[tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (subj_we) begin
         subj_mem[subj_waddr] <= queue_cmd.subj;
      end
      subj_rd_ff <= subj_mem[subj_raddr];
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.name_char     = rsp_char_ff;
   assign rsp_if.found         = rsp_found_ff;
   assign rsp_if.match_length  = rsp_len_ff;
   assign rsp_if.table_index   = rsp_index_ff;
   assign rsp_if.internal_kind = rsp_kind_ff;
   assign rsp_if.last_result   = rsp_last_ff;

endmodule

`default_nettype wire

[design/tag_name_matcher.sv]
// Tag name matcher. Request beats load a table of lowercase tag names (opcode 0),
// feed a subject text (opcode 1) or clear both (opcode 2); the front takes one beat
// a cycle into a four-entry command queue whenever it has room, and the back drains
// it, taking table, clear and plain subject beats straight in its idle state. The
// last subject beat starts a walk over the loaded entries in load order and then
// over includeonly, onlyinclude and noinclude: a candidate not ruled out by length
// gets the delimiter check and then a compare of each character, all through the
// single read port of the table and subject memories. A match then streams its
// name one character per cycle on the response channel (a single no-match beat
// otherwise), slower when the sink holds ready low. No memory clearing pass runs
// after reset.
`timescale 1ns / 1ps
`default_nettype none

module tag_name_matcher #(
   parameter int MAX_TAGS    = 16,
   parameter int MAX_TAG_LEN = 32
) (
   input  logic      clock,
   input  logic      reset,
   tnm_req_if.sink   req_if,
   tnm_rsp_if.source rsp_if
);
   import tnm_pkg::*;

   logic    queue_push;
   logic    queue_pop;
   logic    queue_full;
   logic    queue_empty;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   tnm_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_cmd  (push_cmd)
   );

   tnm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (push_cmd),
      .pop      (queue_pop),
      .pop_cmd  (pop_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   tnm_back #(
      .MAX_TAGS    (MAX_TAGS),
      .MAX_TAG_LEN (MAX_TAG_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (pop_cmd),
      .queue_pop   (queue_pop),
      .rsp_if      (rsp_if)
   );

`ifndef SYNTHESIS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("back popped an empty command queue");

   a_miss_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.found |-> rsp_if.last_result && rsp_if.match_length == '0)
      else $error("no-match beat is not a single zero-length beat");

   a_found_length: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.found |-> rsp_if.match_length != '0)
      else $error("matched name beat with zero length");
`endif

endmodule

`default_nettype wire

[tb/tag_name_matcher_check.sv]
// tag name matcher checker: watches the request and response channels,
// predicts the name beats of every finished subject and compares them in order
// depends on tnm_pkg and the tnm_req_if / tnm_rsp_if interfaces
`timescale 1ns / 1ps

module tag_name_matcher_check #(
   parameter int MAX_TAGS    = 16,
   parameter int MAX_TAG_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   tnm_req_if          req_if,
   tnm_rsp_if          rsp_if,
   output int unsigned mismatch_count,
   output int unsigned beats_in_flight
);
   import tnm_pkg::*;

   localparam int SUBJ_CAP = MAX_TAG_LEN + 3;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_W-1:0]  name_char;
      logic               found;
      logic [LEN_W-1:0]   match_length;
      logic [INDEX_W-1:0] table_index;
      logic [KIND_W-1:0]  internal_kind;
      logic               last_result;
   } name_beat_type;

   typedef logic [CHAR_W-1:0] name_buf_type [MAX_TAG_LEN];

   logic [CHAR_W-1:0] tag_chars [MAX_TAGS][MAX_TAG_LEN];
   int unsigned       tag_len [MAX_TAGS];
   int unsigned       tag_total;
   int unsigned       load_at;
   logic [CHAR_W-1:0] subj_chars [SUBJ_CAP];
   int unsigned       subj_len;
   name_beat_type     expected_name_beats [$];
   int unsigned       mismatches;

   function automatic void clear_tables();
      for (int t = 0; t < MAX_TAGS; t++) begin
         tag_len[t] = 0;
      end
      tag_total = 0;
      load_at   = 0;
      subj_len  = 0;
   endfunction

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c ^ CASE_GAP) : c;
   endfunction

   function automatic bit ends_name(input logic [CHAR_W-1:0] c);
      return c inside {CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE, CH_GT};
   endfunction

   function automatic string builtin_word(input logic [KIND_W-1:0] kind);
      case (kind)
         KIND_INCLUDEONLY: return "includeonly";
         KIND_ONLYINCLUDE: return "onlyinclude";
         KIND_NOINCLUDE:   return "noinclude";
         default:          return "";
      endcase
   endfunction

   // does the name open the subject (from offset off) and stand as a whole word
   function automatic bit name_fits(input name_buf_type name, input int unsigned nlen,
                                    input int unsigned off);
      int unsigned       span;
      logic [CHAR_W-1:0] after;
      if (nlen == 0 || nlen > MAX_TAG_LEN || off + nlen >= subj_len) begin
         return 1'b0;
      end
      span  = subj_len - off;
      after = subj_chars[off + nlen];
      if (!(ends_name(after) || (after == CH_SLASH && nlen + 2 <= span &&
                                 subj_chars[off + nlen + 1] == CH_GT))) begin
         return 1'b0;
      end
      for (int k = 0; k < nlen; k++) begin
         if (fold_case(subj_chars[off + k]) != name[k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void push_name(input name_buf_type name, input int unsigned nlen,
                                     input logic [INDEX_W-1:0] index,
                                     input logic [KIND_W-1:0] kind);
      name_beat_type beat;
      for (int k = 0; k < nlen; k++) begin
         beat.name_char     = name[k];
         beat.found         = 1'b1;
         beat.match_length  = LEN_W'(nlen);
         beat.table_index   = index;
         beat.internal_kind = kind;
         beat.last_result   = (k == nlen - 1);
         expected_name_beats.push_back(beat);
      end
   endfunction

   function automatic void resolve_subject();
      name_buf_type      cand;
      string             word;
      int unsigned       off;
      name_beat_type     miss;
      logic [KIND_W-1:0] kinds [3];
      kinds = '{KIND_INCLUDEONLY, KIND_ONLYINCLUDE, KIND_NOINCLUDE};
      for (int t = 0; t < tag_total; t++) begin
         if (name_fits(tag_chars[t], tag_len[t], 0)) begin
            push_name(tag_chars[t], tag_len[t], INDEX_W'(t), KIND_TABLE);
            return;
         end
      end
      // one leading slash is dropped for the built-in names only
      off = (subj_len > 0 && subj_chars[0] == CH_SLASH) ? 1 : 0;
      for (int b = 0; b < $size(kinds); b++) begin
         word = builtin_word(kinds[b]);
         for (int k = 0; k < word.len(); k++) begin
            cand[k] = word[k];
         end
         if (name_fits(cand, word.len(), off)) begin
            push_name(cand, word.len(), '0, kinds[b]);
            return;
         end
      end
      miss.name_char     = '0;
      miss.found         = 1'b0;
      miss.match_length  = '0;
      miss.table_index   = '0;
      miss.internal_kind = KIND_TABLE;
      miss.last_result   = 1'b1;
      expected_name_beats.push_back(miss);
   endfunction

   function automatic void take_command(input logic [OP_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch, input logic last);
      case (op)
         OP_TAG: begin
            if (tag_total < MAX_TAGS) begin
               if (load_at < MAX_TAG_LEN) begin
                  tag_chars[tag_total][load_at] = ch;
                  load_at++;
               end else begin
                  load_at = MAX_TAG_LEN + 1;
               end
            end
            if (last) begin
               if (tag_total < MAX_TAGS) begin
                  tag_len[tag_total] = load_at;
                  tag_total++;
               end
               load_at = 0;
            end
         end
         OP_SUBJ: begin
            if (subj_len < SUBJ_CAP) begin
               subj_chars[subj_len] = ch;
               subj_len++;
            end
            if (last) begin
               resolve_subject();
               subj_len = 0;
            end
         end
         OP_CLEAR: clear_tables();
         default: ;
      endcase
   endfunction

   function automatic string describe(input name_beat_type b);
      return $sformatf("char %h found %b len %0d index %0d kind %0d last %b",
                       b.name_char, b.found, b.match_length, b.table_index,
                       b.internal_kind, b.last_result);
   endfunction

   function automatic void check_name_beat();
      name_beat_type got;
      name_beat_type want;
      got.name_char     = rsp_if.name_char;
      got.found         = rsp_if.found;
      got.match_length  = rsp_if.match_length;
      got.table_index   = rsp_if.table_index;
      got.internal_kind = rsp_if.internal_kind;
      got.last_result   = rsp_if.last_result;
      if (expected_name_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected name beat: %s", describe(got));
         end
      end else begin
         want = expected_name_beats.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("name beat mismatch: expected %s", describe(want));
               $display("                    actual   %s", describe(got));
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_tables();
         expected_name_beats.delete();
         mismatches = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            take_command(req_if.opcode, req_if.char_value, req_if.last_char);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            check_name_beat();
         end
      end
      beats_in_flight <= expected_name_beats.size();
      mismatch_count  <= mismatches;
   end

endmodule

[tb/tag_name_matcher_test.sv]
// tag name matcher testbench top: clock, reset, request stimulus, response
// back-pressure and the verdict; checking lives in tag_name_matcher_check
// depends on tnm_pkg, the channel interfaces and tag_name_matcher
`timescale 1ns / 1ps

module tag_name_matcher_test;
   import tnm_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_TAGS     = 16;
   localparam int MAX_TAG_LEN  = 32;
   localparam int RANDOM_BEATS = 245;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 200;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned beats_in_flight;
   int unsigned cycle_count = 0;
   int unsigned beats_sent = 0;
   int unsigned idle_pct = 9;
   int unsigned stall_pct = 9;
   int unsigned hold_left = 0;
   bit          hold_request = 1'b0;
   int unsigned random_goal;
   int unsigned session;

   string             table_words [$];
   logic [CHAR_W-1:0] beat_chars [$];
   string             builtins [3] = '{"includeonly", "onlyinclude", "noinclude"};
   logic [CHAR_W-1:0] gaps [6] = '{CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE, CH_GT};

   tnm_req_if req_if ();
   tnm_rsp_if rsp_if ();

   tag_name_matcher #(
      .MAX_TAGS   (MAX_TAGS),
      .MAX_TAG_LEN(MAX_TAG_LEN)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   tag_name_matcher_check #(
      .MAX_TAGS   (MAX_TAGS),
      .MAX_TAG_LEN(MAX_TAG_LEN)
   ) i_check (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .mismatch_count (mismatch_count),
      .beats_in_flight(beats_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response back-pressure, with one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.opcode     <= op;
      req_if.char_value <= ch;
      req_if.last_char  <= last;
      do @(posedge clock); while (!req_if.ready);
      if (op != OP_UNUSED) begin
         beats_sent++;
      end
   endtask

   task automatic send_chars(input logic [OP_W-1:0] op, input bit close);
      for (int k = 0; k < beat_chars.size(); k++) begin
         if ($urandom_range(99) < 3) begin
            send_beat(OP_UNUSED, 8'($urandom), 1'($urandom));
         end
         send_beat(op, beat_chars[k], close && k == beat_chars.size() - 1);
      end
   endtask

   task automatic send_text(input logic [OP_W-1:0] op, input string s);
      beat_chars.delete();
      for (int k = 0; k < s.len(); k++) begin
         beat_chars.push_back(s[k]);
      end
      send_chars(op, 1'b1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (beats_in_flight != 0);
   endtask

   function automatic string random_word(input int unsigned len, input bit odd);
      string w;
      w = "";
      for (int k = 0; k < len; k++) begin
         if (odd) begin
            w = $sformatf("%s%c", w, 8'($urandom_range(1, 255)));
         end else begin
            w = $sformatf("%s%c", w, 8'($urandom_range(8'h61, 8'h7A)));
         end
      end
      return w;
   endfunction

   function automatic string pick_entry();
      int unsigned r;
      string       w;
      r = $urandom_range(99);
      if (r < 55 || table_words.size() == 0) begin
         w = random_word($urandom_range(1, 6), 1'b0);
      end else if (r < 65) begin
         // prefix or extension of an earlier entry, so load order decides
         w = table_words[$urandom_range(table_words.size() - 1)];
         if ($urandom_range(1) != 0) begin
            w = {w, random_word(1, 1'b0)};
         end else begin
            w = w.substr(0, $urandom_range(w.len() - 1));
         end
      end else if (r < 75) begin
         w = builtins[$urandom_range(2)];
      end else if (r < 85) begin
         w = random_word($urandom_range(1, 6), 1'b0);
         w[$urandom_range(w.len() - 1)] = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
      end else if (r < 95) begin
         w = random_word($urandom_range(1, 6), 1'b1);
      end else begin
         w = random_word($urandom_range(7, 12), 1'b0);
      end
      return w;
   endfunction

   task automatic send_subject(input int target, input bit stretch);
      int unsigned       r;
      int unsigned       pick;
      string             base;
      bit                slash;
      bit                garbage;
      logic [CHAR_W-1:0] ch;
      r       = $urandom_range(99);
      slash   = 1'b0;
      garbage = 1'b0;
      base    = "";
      if (target >= 0) begin
         base = table_words[target];
      end else if (r < 55 && table_words.size() != 0) begin
         base = table_words[$urandom_range(table_words.size() - 1)];
      end else if (r < 75) begin
         base  = builtins[$urandom_range(2)];
         slash = $urandom_range(1);
      end else if (r < 85 && table_words.size() != 0) begin
         base  = table_words[$urandom_range(table_words.size() - 1)];
         slash = 1'b1;
      end else begin
         garbage = 1'b1;
      end
      beat_chars.delete();
      if (slash) begin
         beat_chars.push_back(CH_SLASH);
      end
      if (garbage) begin
         repeat ($urandom_range(1, 8)) beat_chars.push_back(8'($urandom));
      end else begin
         for (int k = 0; k < base.len(); k++) begin
            ch = base[k];
            if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(3) == 0) begin
               ch = ch ^ CASE_GAP;
            end
            beat_chars.push_back(ch);
         end
      end
      pick = $urandom_range(9);
      if (pick < 6) begin
         beat_chars.push_back(gaps[pick]);
      end else if (pick == 6) begin
         beat_chars.push_back(CH_SLASH);
         beat_chars.push_back(CH_GT);
      end else if (pick == 7) begin
         // slash not followed by the closing angle
         beat_chars.push_back(CH_SLASH);
         beat_chars.push_back(8'($urandom_range(8'h40, 8'hFF)));
      end else if (pick == 8) begin
         beat_chars.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      repeat (stretch ? 40 : $urandom_range(0, 3)) beat_chars.push_back(8'($urandom));
      send_chars(OP_SUBJ, 1'b1);
   endtask

   task automatic run_session(input int unsigned n);
      int unsigned entries;
      int unsigned subjects;
      string       w;
      idle_pct  = (n == 0) ? 0 : 9;
      stall_pct = idle_pct;
      send_beat(OP_CLEAR, 8'($urandom), 1'($urandom));
      table_words.delete();
      // first session overfills the table under a long hold-off with no idling,
      // second one holds the longest names
      entries = (n == 0) ? MAX_TAGS + 2 : ((n == 1) ? 2 : $urandom_range(1, 5));
      for (int e = 0; e < entries; e++) begin
         if (n == 1 && e == 0) begin
            w = random_word(MAX_TAG_LEN + 2, 1'b0);
         end else if (n == 1 && e == 1) begin
            w = random_word(MAX_TAG_LEN, 1'b0);
         end else if (n == 0) begin
            w = random_word($urandom_range(1, 2), 1'b0);
         end else begin
            w = pick_entry();
         end
         send_text(OP_TAG, w);
         table_words.push_back(w);
      end
      if (n == 1) begin
         send_subject(1, 1'b0);
         send_subject(0, 1'b0);
      end
      if (n == 0) begin
         hold_request = 1'b1;
      end
      subjects = (n == 0) ? 12 : ((n == 1) ? 0 : $urandom_range(3, 8));
      repeat (subjects) send_subject(-1, $urandom_range(19) == 0);
      // broken sequences, cut off by the clear of the next session
      if ($urandom_range(3) == 0) begin
         beat_chars.delete();
         repeat ($urandom_range(1, 4)) beat_chars.push_back(8'($urandom));
         send_chars(OP_SUBJ, 1'b0);
      end
      if ($urandom_range(5) == 0) begin
         send_text(OP_TAG, random_word(1, 1'b0));
         beat_chars.delete();
         repeat ($urandom_range(1, 4)) beat_chars.push_back(8'($urandom));
         send_chars(OP_TAG, 1'b0);
      end
      if (n == 0 || $urandom_range(4) == 0) begin
         wait_drained();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_TAG;
      req_if.char_value = '0;
      req_if.last_char  = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(OP_CLEAR, 8'hFF, 1'b1);
      send_text(OP_TAG, "a");
      send_text(OP_TAG, "B");
      send_text(OP_SUBJ, "A>");
      send_text(OP_SUBJ, "B ");
      send_text(OP_SUBJ, "/noinclude/>");
      send_beat(OP_UNUSED, 8'hFF, 1'b1);
      send_beat(OP_SUBJ, 8'h00, 1'b1);
      send_beat(OP_SUBJ, 8'hFF, 1'b1);
      send_text(OP_SUBJ, "a");
      send_text(OP_SUBJ, "a/x");

      random_goal = beats_sent + RANDOM_BEATS;
      session     = 0;
      while (beats_sent < random_goal) begin
         run_session(session);
         session++;
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
